[hw/rtl/byte_stuffing_framer_deframer_macros.svh]
// Assertion macros for the byte stuffing framer/deframer.
`ifndef BYTE_STUFFING_FRAMER_DEFRAMER_MACROS_SVH
`define BYTE_STUFFING_FRAMER_DEFRAMER_MACROS_SVH

// same-cycle implication, checked out of reset
`define BSFD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("byte stuffing codec check failed");

// next-cycle implication, checked out of reset
`define BSFD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("byte stuffing codec sequencing check failed");

`endif

[hw/rtl/bsfd_pkg.sv]
// Types and constants shared by the byte stuffing framer/deframer.
`timescale 1ns / 1ps
package bsfd_pkg;

	typedef enum logic [1:0] {
		CFG_DIRECTION  = 2'd0,
		CFG_FLAG       = 2'd1,
		CFG_ESCAPE     = 2'd2,
		CFG_COMPLEMENT = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		DIR_ENCODE = 1'b0,
		DIR_DECODE = 1'b1
	} dir_t;

	localparam logic [7:0]  FLAG_RESET       = 8'd126;
	localparam logic [7:0]  ESCAPE_RESET     = 8'd125;
	localparam logic [7:0]  COMPLEMENT_RESET = 8'd32;
	localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

endpackage

[hw/rtl/byte_stuffing_framer_deframer.sv]
// Byte stuffing framer/deframer: input register, result expansion and output register.
// A request's first result is registered in the input register and then the output register before result_valid.
// Throughput: one result per cycle while result_stall is low; a request is held until its last result
// is loaded (1 to 4 results when encoding, 0 or 1 when decoding); a request with no results does not stall.
// Reset (arst_n low, asynchronous): registers to flag 126, escape 125, complement 32,
// encode direction; decoder state cleared; no request held, no result pending.
`timescale 1ns / 1ps
`include "byte_stuffing_framer_deframer_macros.svh"
module byte_stuffing_framer_deframer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  bsfd_pkg::cfg_idx_t cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [7:0]         in_byte,
	input  logic               frame_first,
	input  logic               frame_last,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [7:0]         out_byte,
	output logic               byte_valid,
	output logic               frame_end,
	output logic [15:0]        frame_length,
	output logic               run_last
);
	import bsfd_pkg::*;

	dir_t        direction_q;
	logic [7:0]  flag_q, escape_q, complement_q;
	logic        esc_pend_q, inside_q;
	logic [15:0] count_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1, last_s1;
	logic [1:0]  idx_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        byte_valid_q, frame_end_q, run_last_q;
	logic [15:0] frame_length_q;

	logic [2:0]  n_res;
	logic [1:0]  j;
	logic        esc_hit;
	logic [7:0]  sel_byte;
	logic        sel_bvalid, sel_end;
	logic [15:0] sel_len;
	logic        out_free, load, s1_done, accept, is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q  <= DIR_ENCODE;
			flag_q       <= FLAG_RESET;
			escape_q     <= ESCAPE_RESET;
			complement_q <= COMPLEMENT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DIRECTION:  direction_q  <= dir_t'(cfg_data[0]);
				CFG_FLAG:       flag_q       <= cfg_data;
				CFG_ESCAPE:     escape_q     <= cfg_data;
				CFG_COMPLEMENT: complement_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// result count and selected result for the held request
	always_comb begin
		esc_hit    = (byte_s1 == flag_q) || (byte_s1 == escape_q);
		j          = idx_q - {1'b0, first_s1};
		n_res      = '0;
		sel_byte   = '0;
		sel_bvalid = 1'b1;
		sel_end    = 1'b0;
		sel_len    = '0;
		if (direction_q == DIR_ENCODE) begin
			n_res = 3'(first_s1) + (esc_hit ? 3'd2 : 3'd1) + 3'(last_s1);
			if (first_s1 && idx_q == 2'd0) begin
				sel_byte = flag_q;
			end else if (esc_hit) begin
				unique case (j)
					2'd0:    sel_byte = escape_q;
					2'd1:    sel_byte = byte_s1 ^ complement_q;
					default: sel_byte = flag_q;
				endcase
			end else begin
				sel_byte = (j == 2'd0) ? byte_s1 : flag_q;
			end
		end else begin
			priority if (byte_s1 == flag_q) begin
				n_res      = (inside_q && count_q != '0) ? 3'd1 : 3'd0;
				sel_bvalid = 1'b0;
				sel_end    = 1'b1;
				sel_len    = count_q;
			end else if (!inside_q) begin
				n_res = 3'd0;
			end else if (esc_pend_q) begin
				n_res    = 3'd1;
				sel_byte = byte_s1 ^ complement_q;
			end else if (byte_s1 == escape_q) begin
				n_res = 3'd0;
			end else begin
				n_res    = 3'd1;
				sel_byte = byte_s1;
			end
		end
	end

	assign out_free   = !out_valid_q || !result_stall;
	assign is_last    = ({1'b0, idx_q} == n_res - 3'd1);
	assign load       = valid_s1 && (n_res != 3'd0) && out_free;
	assign s1_done    = valid_s1 && ((n_res == 3'd0) || (out_free && is_last));
	assign item_stall = valid_s1 && !s1_done;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (s1_done)
				valid_s1 <= 1'b0;
			if (s1_done)
				idx_q <= '0;
			else if (load)
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= in_byte;
			first_s1 <= frame_first;
			last_s1  <= frame_last;
		end
	end

	// decoder state moves on once the held request is finished, in decode direction only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_pend_q <= 1'b0;
			inside_q   <= 1'b0;
			count_q    <= '0;
		end else if (s1_done && direction_q == DIR_DECODE) begin
			priority if (byte_s1 == flag_q) begin
				inside_q   <= 1'b1;
				count_q    <= '0;
				esc_pend_q <= 1'b0;
			end else if (inside_q) begin
				if (!esc_pend_q && byte_s1 == escape_q) begin
					esc_pend_q <= 1'b1;
				end else begin
					esc_pend_q <= 1'b0;
					if (count_q != COUNT_MAX)
						count_q <= count_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= load;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q     <= sel_byte;
			byte_valid_q   <= sel_bvalid;
			frame_end_q    <= sel_end;
			frame_length_q <= sel_len;
			run_last_q     <= is_last;
		end
	end

	assign result_valid = out_valid_q;
	assign out_byte     = out_byte_q;
	assign byte_valid   = byte_valid_q;
	assign frame_end    = frame_end_q;
	assign frame_length = frame_length_q;
	assign run_last     = run_last_q;

	`BSFD_ASSERT_IMP(a_idx_in_range, valid_s1, ({1'b0, idx_q} < n_res) || (idx_q == 2'd0))
	`BSFD_ASSERT_IMP(a_pend_inside, esc_pend_q, inside_q)
	`BSFD_ASSERT_IMP(a_end_fields, out_valid_q && frame_end_q, !byte_valid_q && frame_length_q != 16'd0 && run_last_q)
	`BSFD_ASSERT_NXT(a_idx_step, valid_s1 && load && !s1_done, valid_s1 && idx_q == $past(idx_q) + 2'd1)

endmodule
